@@ hw/rtl/md5hs_pkg.sv @@
// md5hs_pkg: shared types, constants and round helper functions for the md5 stream unit
// no dependencies; imported by md5hs_regfile, md5hs_core and md5_hash_stream_unit
`timescale 1ns / 1ps

package md5hs_pkg;

  localparam logic [31:0] MD5_IV_A = 32'h67452301;
  localparam logic [31:0] MD5_IV_B = 32'hEFCDAB89;
  localparam logic [31:0] MD5_IV_C = 32'h98BADCFE;
  localparam logic [31:0] MD5_IV_D = 32'h10325476;

  localparam int unsigned WORDS_PER_BLOCK = 16;
  localparam int unsigned WORD_ADDR_W     = $clog2(WORDS_PER_BLOCK);

  // round groups
  localparam logic [1:0] GRP_F = 2'd0;
  localparam logic [1:0] GRP_G = 2'd1;
  localparam logic [1:0] GRP_H = 2'd2;
  localparam logic [1:0] GRP_I = 2'd3;

  typedef struct packed {
    logic start;  // load working words from chaining words, run 64 rounds
    logic init;   // chaining words back to the initial values
  } core_ctrl_t;

  typedef struct packed {
    logic busy;   // rounds or final add in progress
    logic done;   // final add happens at this edge
  } core_stat_t;

  function automatic logic [31:0] k_const(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h6d0312d8;
      6'd60: k = 32'h8c1fdc3b;  6'd61: k = 32'h5bfebc37;
      6'd62: k = 32'h4f019c47;  6'd63: k = 32'h7f9305a0;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // rotate amount, indexed by round group and round low bits
  function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
    logic [4:0] s;
    unique case ({rnd[5:4], rnd[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // message word used by a round, all arithmetic mod 16
  function automatic logic [WORD_ADDR_W-1:0] msg_index(input logic [5:0] rnd);
    logic [WORD_ADDR_W-1:0] r;
    logic [WORD_ADDR_W-1:0] g;
    r = rnd[WORD_ADDR_W-1:0];
    unique case (rnd[5:4])
      GRP_F:   g = r;
      GRP_G:   g = WORD_ADDR_W'(4'd5 * r + 4'd1);
      GRP_H:   g = WORD_ADDR_W'(4'd3 * r + 4'd5);
      GRP_I:   g = WORD_ADDR_W'(4'd7 * r);
      default: g = r;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] round_fn(input logic [1:0] grp, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    unique case (grp)
      GRP_F:   f = (b & c) | (~b & d);
      GRP_G:   f = (b & d) | (c & ~d);
      GRP_H:   f = b ^ c ^ d;
      GRP_I:   f = c ^ (b | ~d);
      default: f = 32'h0;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

endpackage

@@ hw/rtl/md5hs_regfile.sv @@
// md5hs_regfile: 16 x 32 block buffer with byte-lane write strobes
// depends on md5hs_pkg for the word address width
`timescale 1ns / 1ps

module md5hs_regfile import md5hs_pkg::*; (
  input  logic                   clk,
  input  logic                   we,
  input  logic [WORD_ADDR_W-1:0] waddr,
  input  logic [3:0]             wstrb,
  input  logic [31:0]            wdata,
  input  logic [WORD_ADDR_W-1:0] raddr,
  output logic [31:0]            rdata
);

  logic [31:0] words [WORDS_PER_BLOCK];

  always_ff @(posedge clk) begin
    for (int lane = 0; lane < 4; lane++) begin
      if (we && wstrb[lane]) begin
        words[waddr][lane*8 +: 8] <= wdata[lane*8 +: 8];
      end
    end
  end

  assign rdata = words[raddr];

endmodule

@@ hw/rtl/md5hs_core.sv @@
// md5hs_core: chaining words and one shared md5 round unit, 64 rounds then a final add
// depends on md5hs_pkg; reads message words from md5hs_regfile through msg_addr
`timescale 1ns / 1ps

module md5hs_core import md5hs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  core_ctrl_t             ctrl,
  input  logic [1:0]             word_sel,
  input  logic [31:0]            msg_word,
  output logic [WORD_ADDR_W-1:0] msg_addr,
  output logic [31:0]            cv_word,
  output core_stat_t             stat
);

  logic [31:0] cv [4];
  logic [31:0] a, b, c, d;
  logic [5:0]  rnd;
  logic        running;
  logic        add_pend;
  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] b_next;

  // one round per cycle
  always_comb begin
    f      = round_fn(rnd[5:4], b, c, d);
    sum    = a + f + k_const(rnd) + msg_word;
    b_next = b + rotl32(sum, rot_amt(rnd));
  end

  assign msg_addr  = msg_index(rnd);
  assign cv_word   = cv[word_sel];
  assign stat.busy = running | add_pend;
  assign stat.done = add_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      add_pend <= 1'b0;
      rnd      <= '0;
    end else if (ctrl.start) begin
      running <= 1'b1;
      rnd     <= '0;
    end else if (running) begin
      rnd <= rnd + 6'd1;
      if (&rnd) begin
        running  <= 1'b0;
        add_pend <= 1'b1;
      end
    end else if (add_pend) begin
      add_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.init) begin
      cv[0] <= MD5_IV_A;
      cv[1] <= MD5_IV_B;
      cv[2] <= MD5_IV_C;
      cv[3] <= MD5_IV_D;
    end else if (add_pend) begin
      cv[0] <= cv[0] + a;
      cv[1] <= cv[1] + b;
      cv[2] <= cv[2] + c;
      cv[3] <= cv[3] + d;
    end
  end

  // working words, no reset needed
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      a <= cv[0];
      b <= cv[1];
      c <= cv[2];
      d <= cv[3];
    end else if (running) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b_next;
    end
  end

endmodule

@@ hw/rtl/md5_hash_stream_unit.sv @@
// md5_hash_stream_unit: streaming md5, one message byte per item, four digest words out
// depends on md5hs_pkg, md5hs_regfile and md5hs_core
// a byte item that completes a block also starts a compression (64 rounds, then the final add)
// and the input stalls until it ends; the block rate is set by the single shared round unit
// end item: up to two compressions, each final block preceded by its padding word writes,
// then 4 result items
// reset (synchronous, active high): chaining words to the md5 initial values, length and
// byte position to zero, sequencer idle; the block buffer is not cleared
`timescale 1ns / 1ps

module md5_hash_stream_unit import md5hs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  // digest channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        digest_last
);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PAD  = 2'd1;
  localparam logic [1:0] S_COMP = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  // where to go once a compression finishes
  localparam logic [1:0] RET_IDLE = 2'd0;  // full block mid-message
  localparam logic [1:0] RET_PAD  = 2'd1;  // full block on the end item, padding still to do
  localparam logic [1:0] RET_PAD2 = 2'd2;  // padding spilled over, length block next
  localparam logic [1:0] RET_OUT  = 2'd3;  // length block done, emit digest

  localparam logic [WORD_ADDR_W-1:0] LEN_LO_WORD = WORD_ADDR_W'(WORDS_PER_BLOCK - 2);
  localparam logic [WORD_ADDR_W-1:0] LEN_HI_WORD = WORD_ADDR_W'(WORDS_PER_BLOCK - 1);
  localparam logic [7:0]             PAD_MARKER  = 8'h80;
  localparam logic [1:0]             LAST_WORD   = 2'd3;

  logic [1:0]             state, state_next;
  logic [1:0]             ret, ret_next;
  logic [5:0]             pos, pos_next;
  logic [63:0]            bitlen, bitlen_next;
  logic [WORD_ADDR_W-1:0] pad_word, pad_word_next;
  logic                   mark, mark_next;
  logic                   second, second_next;
  logic [1:0]             out_idx, out_idx_next;

  logic                   in_acc;
  logic                   out_acc;
  logic                   len_blk;

  // block buffer write port
  logic                   buf_we;
  logic [WORD_ADDR_W-1:0] buf_waddr;
  logic [3:0]             buf_wstrb;
  logic [31:0]            buf_wdata;
  logic [WORD_ADDR_W-1:0] buf_raddr;
  logic [31:0]            buf_rdata;

  core_ctrl_t             ctrl;
  core_stat_t             stat;
  logic [31:0]            cv_word;

  md5hs_regfile u_regfile (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wstrb (buf_wstrb),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  md5hs_core u_core (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .word_sel (out_idx),
    .msg_word (buf_rdata),
    .msg_addr (buf_raddr),
    .cv_word  (cv_word),
    .stat     (stat)
  );

  assign in_stall    = (state != S_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign out_valid   = (state == S_OUT);
  assign out_acc     = out_valid && !out_stall;
  assign digest_word = cv_word;
  assign word_index  = out_idx;
  assign digest_last = (out_idx == LAST_WORD);

  // the length goes into this block unless the end marker landed at byte 56 or later
  assign len_blk = second || (pos[5:3] != 3'b111);

  // buffer writes: message bytes when idle, one padding word per cycle when padding
  always_comb begin
    buf_we    = 1'b0;
    buf_waddr = pos[5:2];
    buf_wstrb = 4'b0000;
    buf_wdata = '0;
    if (state == S_IDLE && in_acc && has_byte) begin
      buf_we    = 1'b1;
      buf_wstrb = 4'b0001 << pos[1:0];
      buf_wdata = {4{data_byte}};
    end else if (state == S_PAD) begin
      buf_we    = 1'b1;
      buf_waddr = pad_word;
      if (mark) begin
        // marker byte at the next free lane, zero the lanes above, keep the ones below
        buf_wstrb = 4'b1111 << pos[1:0];
        buf_wdata = {24'h0, PAD_MARKER} << {pos[1:0], 3'b000};
      end else begin
        buf_wstrb = 4'b1111;
        if (len_blk && pad_word == LEN_LO_WORD) begin
          buf_wdata = bitlen[31:0];
        end else if (len_blk && pad_word == LEN_HI_WORD) begin
          buf_wdata = bitlen[63:32];
        end
      end
    end
  end

  // sequencer
  always_comb begin
    state_next    = state;
    ret_next      = ret;
    pos_next      = pos;
    bitlen_next   = bitlen;
    pad_word_next = pad_word;
    mark_next     = mark;
    second_next   = second;
    out_idx_next  = out_idx;
    ctrl.start    = 1'b0;
    ctrl.init     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (has_byte) begin
            bitlen_next = bitlen + 64'd8;
            pos_next    = pos + 6'd1;
          end
          if (has_byte && (&pos)) begin
            // block is full, compress before anything else
            ctrl.start = 1'b1;
            state_next = S_COMP;
            ret_next   = end_of_message ? RET_PAD : RET_IDLE;
          end else if (end_of_message) begin
            state_next    = S_PAD;
            pad_word_next = pos_next[5:2];
            mark_next     = 1'b1;
            second_next   = 1'b0;
          end
        end
      end
      S_PAD: begin
        mark_next     = 1'b0;
        pad_word_next = pad_word + WORD_ADDR_W'(1);  // wraps to word 0 for a second pass
        if (pad_word == LEN_HI_WORD) begin
          ctrl.start = 1'b1;
          state_next = S_COMP;
          ret_next   = len_blk ? RET_OUT : RET_PAD2;
        end
      end
      S_COMP: begin
        if (stat.done) begin
          unique case (ret)
            RET_IDLE: state_next = S_IDLE;
            RET_PAD: begin
              state_next    = S_PAD;
              pad_word_next = '0;
              mark_next     = 1'b1;
              second_next   = 1'b0;
            end
            RET_PAD2: begin
              state_next    = S_PAD;
              pad_word_next = '0;
              mark_next     = 1'b0;
              second_next   = 1'b1;
            end
            RET_OUT: begin
              state_next   = S_OUT;
              out_idx_next = '0;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_OUT: begin
        if (out_acc) begin
          out_idx_next = out_idx + 2'd1;
          if (out_idx == LAST_WORD) begin
            // digest delivered, start a fresh message
            ctrl.init   = 1'b1;
            pos_next    = '0;
            bitlen_next = '0;
            second_next = 1'b0;
            state_next  = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret      <= RET_IDLE;
      pos      <= '0;
      bitlen   <= '0;
      pad_word <= '0;
      mark     <= 1'b0;
      second   <= 1'b0;
      out_idx  <= '0;
    end else begin
      state    <= state_next;
      ret      <= ret_next;
      pos      <= pos_next;
      bitlen   <= bitlen_next;
      pad_word <= pad_word_next;
      mark     <= mark_next;
      second   <= second_next;
      out_idx  <= out_idx_next;
    end
  end

  // the round unit only runs while the sequencer waits on it
  assert property (@(posedge clk) disable iff (rst) stat.busy |-> state == S_COMP)
    else $error("round unit busy outside compression");

  // a compression is never started on top of a running one
  assert property (@(posedge clk) disable iff (rst) ctrl.start |-> !stat.busy)
    else $error("compression started while round unit busy");

  // no input item is taken while digest words are pending
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input accepted during digest output");

  // after the last digest word the message state is back to empty
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && !out_stall && digest_last |=> pos == '0 && bitlen == '0)
    else $error("message state not cleared after digest");

endmodule

@@ dv/tb_top.sv @@
// tb_top: self-checking testbench for md5_hash_stream_unit, byte items in, digest words out
// depends only on the rtl (md5hs_pkg and the md5_hash_stream_unit sources); holds its own md5 predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned WATCHDOG_LIMIT = 2000;  // quiet cycles before the run is abandoned
  localparam int unsigned DRAIN_CYCLES   = 200;   // two compressions plus padding, with margin
  localparam int unsigned ITEM_TARGET    = 360;   // byte and end items to send
  localparam int unsigned PRESSURE_AT    = 20;    // digest words seen before the long hold
  localparam int unsigned PRESSURE_HOLD  = 300;   // cycles the digest side stays stalled

  // per-step additive constants of this variant (last five differ from rfc 1321)
  localparam logic [31:0] STEP_ADD [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h6d0312d8,
    32'h8c1fdc3b, 32'h5bfebc37, 32'h4f019c47, 32'h7f9305a0
  };

  // rotate amounts, four per round group
  localparam int unsigned STEP_ROT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hEFCDAB89;
  localparam logic [31:0] INIT_C = 32'h98BADCFE;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // message lengths around the padding boundaries: last one-block pad, first two-block pad,
  // a marker in the last byte of a block, and a full block followed by a padding-only block
  localparam int unsigned BOUNDARY_LENS [4] = '{55, 56, 63, 64};

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eom;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] word_val;
    logic [1:0]  word_sel;
    logic        is_last;
  } digest_word_t;

  // directed rows; digests cannot be read off by eye, so every row goes through the predictor
  localparam int unsigned N_DIRECTED = 17;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b1},  // empty message straight after reset
    '{8'hff, 1'b0, 1'b0},  // idle item, data must be ignored
    '{8'hff, 1'b0, 1'b1},  // empty message again, junk on the data lines
    '{8'h00, 1'b1, 1'b1},  // one zero byte carried by the end item
    '{8'hff, 1'b1, 1'b1},  // one all-ones byte carried by the end item
    '{8'h80, 1'b1, 1'b0},  // byte that looks like the pad marker
    '{8'h7f, 1'b1, 1'b0},
    '{8'hff, 1'b0, 1'b0},  // idle item in the middle of a message
    '{8'h01, 1'b1, 1'b0},
    '{8'hfe, 1'b1, 1'b0},
    '{8'h55, 1'b0, 1'b1},  // empty end item closes a four-byte message
    '{8'h61, 1'b1, 1'b0},  // "abc"
    '{8'h62, 1'b1, 1'b0},
    '{8'h63, 1'b1, 1'b1},
    '{8'haa, 1'b0, 1'b0},  // two idle items back to back
    '{8'h55, 1'b0, 1'b0},
    '{8'ha5, 1'b1, 1'b1}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        has_byte = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        digest_last;

  // predictor state: chaining words, block being filled, fill position, bit length
  logic [31:0] chain_q [4];
  logic [31:0] blk_words [16];
  logic [5:0]  blk_pos;
  logic [63:0] bit_len;

  digest_word_t pending_digest_q [$];

  int unsigned error_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned noise_sent    = 0;
  int unsigned messages_done = 0;
  int unsigned words_checked = 0;
  int unsigned quiet_cycles  = 0;
  bit          burst_mode    = 1'b0;
  bit          pressure_done = 1'b0;

  md5_hash_stream_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .digest_last    (digest_last)
  );

  always #6 clk = ~clk;

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // md5 predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned s);
    // every rotate amount in the table is between 4 and 23
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void restart_digest();
    chain_q[0] = INIT_A;
    chain_q[1] = INIT_B;
    chain_q[2] = INIT_C;
    chain_q[3] = INIT_D;
    foreach (blk_words[w]) blk_words[w] = '0;
    blk_pos = '0;
    bit_len = '0;
  endfunction

  function automatic void put_block_byte(input int unsigned pos, input logic [7:0] v);
    blk_words[pos / 4][(pos % 4) * 8 +: 8] = v;
  endfunction

  // 64 steps over the current block, then fold into the chaining words
  function automatic void compress_block();
    logic [31:0] a, b, c, d, f, t;
    int unsigned g;
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    for (int unsigned i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rol32(a + f + STEP_ADD[i] + blk_words[g], STEP_ROT[(i / 16) * 4 + i % 4]);
      a = t;
    end
    chain_q[0] += a;
    chain_q[1] += b;
    chain_q[2] += c;
    chain_q[3] += d;
  endfunction

  // apply one accepted item; an end item queues the four digest words it causes
  function automatic void predict_item(input logic [7:0] d, input logic hb, input logic eom);
    int unsigned p;
    if (hb) begin
      put_block_byte(blk_pos, d);
      bit_len += 64'd8;  // wraps at 2^64, far beyond any simulated message
      blk_pos += 6'd1;
      if (blk_pos == 6'd0) compress_block();
    end
    if (!eom) return;
    p = blk_pos;
    put_block_byte(p, PAD_MARK);
    for (int unsigned k = p + 1; k < 64; k++) put_block_byte(k, 8'h00);
    // no room for the length: pad block goes out alone, length in a fresh block
    if (p >= 56) begin
      compress_block();
      foreach (blk_words[w]) blk_words[w] = '0;
    end
    blk_words[14] = bit_len[31:0];
    blk_words[15] = bit_len[63:32];
    compress_block();
    for (int unsigned k = 0; k < 4; k++) begin
      pending_digest_q.push_back('{word_val: chain_q[k], word_sel: 2'(k), is_last: (k == 3)});
    end
    messages_done++;
    restart_digest();
  endfunction

  initial restart_digest();

  // ---------------------------------------------------------------------------
  // item source
  // ---------------------------------------------------------------------------

  // valid stays high across back-to-back items, so it is only lowered when a gap is drawn
  task automatic send_item(input logic [7:0] d, input logic hb, input logic eom);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= d;
    has_byte       <= hb;
    end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(d, hb, eom);
    if (hb || eom) items_sent++;
    else noise_sent++;
  endtask

  // one message of random content; the end rides on the last byte or comes as an empty item
  task automatic send_message(input int unsigned len);
    bit tail_byte;
    burst_mode = ($urandom_range(0, 3) == 0);
    tail_byte  = (len != 0) && ($urandom_range(0, 1) == 1);
    for (int unsigned n = 0; n < len; n++) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, tail_byte && (n == len - 1));
    end
    if (!tail_byte) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin : stimulus
    int unsigned len;
    int unsigned pick;
    while (rst) @(posedge clk);

    // directed table
    for (int unsigned r = 0; r < N_DIRECTED; r++) begin
      burst_mode = ($urandom_range(0, 2) == 0);
      send_item(DIRECTED[r].data, DIRECTED[r].has, DIRECTED[r].eom);
    end

    // padding boundaries with random content
    foreach (BOUNDARY_LENS[i]) send_message(BOUNDARY_LENS[i]);

    // random messages, mostly short so that digests come often
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(0, 24);
      else if (pick < 8) len = $urandom_range(52, 68);
      else len = $urandom_range(0, 140);
      send_message(len);
    end
    in_valid <= 1'b0;

    while (pending_digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d messages: %0d byte/end items, %0d idle items, %0d digest words",
             messages_done, items_sent, noise_sent, words_checked);
    $display("boundary lengths 55/56/63/64 and empty messages included, one long digest hold");
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // digest sink and checker
  // ---------------------------------------------------------------------------

  task automatic check_digest_word();
    digest_word_t want;
    if (pending_digest_q.size() == 0) begin
      $error("digest word %08h (index %0d) with no digest expected", digest_word, word_index);
      error_count++;
      return;
    end
    want = pending_digest_q.pop_front();
    words_checked++;
    if (digest_word !== want.word_val) begin
      $error("digest_word: expected %08h, got %08h", want.word_val, digest_word);
      error_count++;
    end
    if (word_index !== want.word_sel) begin
      $error("word_index: expected %0d, got %0d", want.word_sel, word_index);
      error_count++;
    end
    if (digest_last !== want.is_last) begin
      $error("digest_last: expected %0d, got %0d", want.is_last, digest_last);
      error_count++;
    end
  endtask

  initial begin : digest_sink
    int unsigned hold;
    while (rst) @(posedge clk);
    forever begin
      // one long hold so the unit backs up and stalls its input while items keep coming
      if (!pressure_done && words_checked >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        // stall first, then wait for a digest so the hold really blocks the unit
        out_stall <= 1'b1;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
        hold = PRESSURE_HOLD;
      end else begin
        hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_digest_word();
    end
  end

  // watchdog: a run of cycles with no handshake on either side means a hang
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
